/* rtl/sorted_table_binary_search_macros.svh */
// Assertion macros shared by the sorted table search RTL.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, skipped while reset is low
`define STBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds through reset
`define STBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STBS_ASSERT(lbl, prop, msg)
`define STBS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/stbs_pkg.sv */
// Shared constants and controller/datapath interface types for the table search.
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int OP_W            = 2;
  localparam int VALUE_W         = 32;
  localparam int POS_W           = 11;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  typedef struct packed {
    logic clear;     // empty the table
    logic append;    // write word at entry_count
    logic start;     // latch key, head = 0, tail = count
    logic probe;     // read entry at mid
    logic step;      // narrow range using last compare
    logic hit;       // record match
    logic miss;      // record no match
    logic load_out;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic range_empty;  // head >= tail
    logic key_hit;      // probed entry equals key
    logic key_less;     // probed entry below key
    logic out_free;     // output register can take a word
  } sts_t;

endpackage

/* rtl/stbs_ctrl.sv */
// Sequencer for clear, append and binary search items.
`timescale 1ns / 1ps
`include "sorted_table_binary_search_macros.svh"

module stbs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [stbs_pkg::OP_W-1:0]   in_op,
  input  stbs_pkg::sts_t              sts,
  output stbs_pkg::cmd_t              cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            stbs_pkg::OP_CLEAR:  cmd.clear  = 1'b1;
            stbs_pkg::OP_APPEND: cmd.append = 1'b1;
            stbs_pkg::OP_SEARCH: begin
              cmd.start = 1'b1;
              state_nxt = S_CHECK;
            end
            default: ;  // unused code, dropped
          endcase
        end
      end
      S_CHECK: begin
        if (sts.range_empty) begin
          cmd.miss  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.key_hit) begin
          cmd.hit   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `STBS_ASSERT(a_load_when_free, cmd.load_out |-> sts.out_free, "result loaded over a pending word")
  `STBS_ASSERT(a_probe_then_cmp, cmd.probe |=> (state_r == S_CMP), "probe not followed by compare")
  `STBS_ASSERT(a_start_from_idle, cmd.start |=> (state_r == S_CHECK && !in_ready), "search start lost")

endmodule

/* rtl/stbs_dp.sv */
// Table memory, entry count, search range registers and output register.
`timescale 1ns / 1ps
`include "sorted_table_binary_search_macros.svh"

module stbs_dp #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [stbs_pkg::VALUE_W-1:0] in_value,
  input  stbs_pkg::cmd_t                      cmd,
  output stbs_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic signed [stbs_pkg::POS_W-1:0]   out_position
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int VW    = stbs_pkg::VALUE_W;
  localparam int PW    = stbs_pkg::POS_W;

  logic [VW-1:0]        table_mem_r [TABLE_DEPTH];
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     head_r;
  logic [CNT_W-1:0]     tail_r;
  logic [IDX_W-1:0]     mid_r;
  logic signed [VW-1:0] key_r;
  logic signed [VW-1:0] rd_data_r;
  logic                 res_found_r;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic [PW-1:0]        out_pos_r;

  logic [CNT_W:0]       range_sum;
  logic [IDX_W-1:0]     mid_idx;
  logic                 has_room;
  logic [31:0]          mid_ext;

  assign range_sum = {1'b0, head_r} + {1'b0, tail_r};
  // mid < count <= depth, so the low bits always address a real entry
  assign mid_idx   = range_sum[IDX_W:1];
  assign has_room  = (count_r < CNT_W'(TABLE_DEPTH));
  assign mid_ext   = 32'(mid_r);

  assign sts.range_empty = (head_r >= tail_r);
  assign sts.key_hit     = (rd_data_r == key_r);
  assign sts.key_less    = (rd_data_r < key_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.append && has_room) begin
      table_mem_r[count_r[IDX_W-1:0]] <= in_value;
    end
    if (cmd.probe) begin
      rd_data_r <= table_mem_r[mid_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.append && has_room) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      head_r <= '0;
      tail_r <= count_r;
      key_r  <= in_value;
    end else if (cmd.step) begin
      if (sts.key_less) begin
        head_r <= CNT_W'(mid_r) + 1'b1;
      end else begin
        tail_r <= CNT_W'(mid_r);
      end
    end
    if (cmd.probe) begin
      mid_r <= mid_idx;
    end
    if (cmd.hit) begin
      res_found_r <= 1'b1;
    end else if (cmd.miss) begin
      res_found_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_found_r <= res_found_r;
      out_pos_r   <= res_found_r ? mid_ext[PW-1:0] : '1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = $signed(out_pos_r);

  `STBS_ASSERT(a_count_bound, count_r <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
  `STBS_ASSERT(a_probe_range, cmd.probe |-> (head_r < tail_r && tail_r <= count_r), "probe outside written range")
  `STBS_ASSERT(a_hit_in_range, cmd.hit |-> (CNT_W'(mid_r) < count_r), "match reported beyond count")

endmodule

/* rtl/sorted_table_binary_search.sv */
// Sorted table with binary search: top level joining sequencer and datapath.
//
// Input channel (in_valid/in_ready): one word per item, in_op selects clear (0),
// append of in_value (1) or search for in_value (2); code 3 is dropped.
// Output channel (out_valid/out_ready): one word per search, out_found and
// out_position (index of the match, or -1 when absent or the table is empty).
// Clear and append give no word and leave the sequencer idle. A search runs
// probes (synchronous memory read, then compare and range update), at most
// log2(depth)+1 of them, then a final range check on a miss, then the load
// of the output register. One item is in flight at a time; in_ready is high
// only while the sequencer is idle, so the next item can be accepted in the
// same cycle that out_valid rises.
// Reset clears the entry count and the output valid flag; table contents are
// not cleared and are only read below the count.
// If out_ready stays low, a finished search waits until the pending output
// word is taken, and no new item is accepted meanwhile. Clear and append
// items are still accepted while an earlier result waits.
`timescale 1ns / 1ps

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [stbs_pkg::OP_W-1:0]    in_op,
  input  logic signed [stbs_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic signed [stbs_pkg::POS_W-1:0]   out_position
);

  stbs_pkg::cmd_t cmd;
  stbs_pkg::sts_t sts;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_position (out_position)
  );

endmodule

/* test/sorted_table_binary_search_tb.sv */
// Testbench for the sorted table search: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 800_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
  } word_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } answer_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_op = OP_CLEAR;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic signed [POS_W-1:0] out_position;

  word_t words_to_send[$];
  answer_t answers_due[$];
  word_t next_word;
  answer_t oldest_answer;

  // predictor state, updated as words are accepted
  logic signed [VALUE_W-1:0] entries [DEPTH];
  int unsigned entry_count = 0;

  // what the stimulus side believes the table holds, used to pick keys
  logic signed [VALUE_W-1:0] planned_entries[$];
  int phase_words;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  sorted_table_binary_search u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_position (out_position)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // half-open binary search over entries [0, entry_count)
  function automatic answer_t search_entries(logic signed [VALUE_W-1:0] key);
    answer_t r;
    int unsigned head;
    int unsigned tail;
    int unsigned mid;
    r.found = 1'b0;
    r.position = '1;
    head = 0;
    tail = entry_count;
    while (head < tail) begin
      mid = (head + tail) >> 1;
      if (entries[mid] == key) begin
        r.found = 1'b1;
        r.position = mid[POS_W-1:0];
        return r;
      end
      if (entries[mid] < key) head = mid + 1;
      else tail = mid;
    end
    return r;
  endfunction

  function automatic void apply_word(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value);
    case (op)
      OP_CLEAR: entry_count = 0;
      OP_APPEND: begin
        if (entry_count < DEPTH) begin
          entries[entry_count] = value;
          entry_count++;
        end
      end
      OP_SEARCH: answers_due.push_back(search_entries(value));
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic add_word(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value);
    word_t w;
    w.op = op;
    w.value = value;
    words_to_send.push_back(w);
    if (op == OP_CLEAR) begin
      planned_entries.delete();
      phase_words++;
    end else if (op == OP_APPEND) begin
      if (planned_entries.size() < DEPTH) begin
        planned_entries.push_back(value);
        phase_words++;
      end
    end else if (op == OP_SEARCH) begin
      phase_words++;
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_key();
    int sel;
    int idx;
    sel = $urandom_range(9);
    if (planned_entries.size() == 0 || sel == 9) return $urandom;
    if (sel == 7) return 32'sh8000_0000;
    if (sel == 8) return 32'sh7fff_ffff;
    idx = $urandom_range(planned_entries.size() - 1);
    if (sel == 5) return planned_entries[idx] + 1;
    if (sel == 6) return planned_entries[idx] - 1;
    return planned_entries[idx];
  endfunction

  // appends n values in ascending order, some of them repeated
  task automatic append_sorted(input int n);
    logic signed [VALUE_W-1:0] vals[$];
    logic signed [VALUE_W-1:0] v;
    int j;
    for (int i = 0; i < n; i++) begin
      if (vals.size() != 0 && $urandom_range(9) == 0) v = vals[$urandom_range(vals.size() - 1)];
      else v = $urandom;
      j = 0;
      while (j < vals.size() && vals[j] < v) j++;
      vals.insert(j, v);
    end
    foreach (vals[i]) add_word(OP_APPEND, vals[i]);
  endtask

  task automatic add_searches(input int n);
    for (int i = 0; i < n; i++) add_word(OP_SEARCH, pick_key());
  endtask

  task automatic fill_random_phase(input int target);
    int r;
    phase_words = 0;
    while (phase_words < target) begin
      r = $urandom_range(99);
      if (r < 75) begin
        add_word(OP_CLEAR, $urandom);
        append_sorted($urandom_range(40));
        add_searches($urandom_range(1, 8));
      end else if (r < 85) begin
        // unsorted content: the probe path may miss keys that are present
        if ($urandom_range(1)) add_word(OP_CLEAR, $urandom);
        for (int i = $urandom_range(1, 10); i > 0; i--) add_word(OP_APPEND, $urandom);
        add_searches($urandom_range(1, 4));
      end else if (r < 92) begin
        if ($urandom_range(1)) add_word(OP_UNUSED, $urandom);
        else add_word(OP_SEARCH, $urandom);
      end else begin
        append_sorted($urandom_range(1, 6));
        add_searches($urandom_range(1, 3));
      end
    end
  endtask

  task automatic fill_directed();
    add_word(OP_SEARCH, 32'sd0);              // empty table
    add_word(OP_UNUSED, 32'shffff_ffff);
    add_word(OP_APPEND, 32'sh8000_0000);
    add_word(OP_APPEND, -32'sd1);
    add_word(OP_APPEND, 32'sd0);
    add_word(OP_APPEND, 32'sd5);
    add_word(OP_APPEND, 32'sd5);              // duplicate
    add_word(OP_APPEND, 32'sh7fff_ffff);
    add_word(OP_SEARCH, 32'sh8000_0000);
    add_word(OP_SEARCH, 32'sh7fff_ffff);
    add_word(OP_SEARCH, -32'sd1);
    add_word(OP_SEARCH, 32'sd0);
    add_word(OP_SEARCH, 32'sd5);
    add_word(OP_SEARCH, 32'sd3);
    add_word(OP_SEARCH, 32'sh7fff_fffe);
    add_word(OP_UNUSED, 32'sd5);
    add_word(OP_SEARCH, 32'sd5);
    add_word(OP_CLEAR, 32'sd0);
    add_word(OP_SEARCH, 32'sd5);
    add_word(OP_APPEND, 32'sd10);
    add_word(OP_APPEND, 32'sd1);
    add_word(OP_APPEND, 32'sd7);
    add_word(OP_SEARCH, 32'sd1);
    add_word(OP_SEARCH, 32'sd10);
    add_word(OP_CLEAR, 32'sd0);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_word(in_op, in_value);
      if (!in_valid || in_ready) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = words_to_send.pop_front();
          in_valid <= 1'b1;
          in_op <= next_word.op;
          in_value <= next_word.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result word with no search outstanding",
                          32'(out_position), 32'(out_found));
        end else begin
          oldest_answer = answers_due.pop_front();
          if (out_found !== oldest_answer.found)
            report_mismatch("found", 32'(out_found), 32'(oldest_answer.found));
          if (out_position !== oldest_answer.position)
            report_mismatch("position", 32'(out_position), 32'(oldest_answer.position));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 9 : 0;
      if (phase == 0) fill_directed();
      fill_random_phase(180);
      while (words_to_send.size() != 0) @(posedge clk);
    end

    while (answers_due.size() != 0 || words_to_send.size() != 0 || in_valid) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
